// File: rtl/core/b64sd_pkg.sv
`default_nettype none

package b64sd_pkg;

  localparam int CAP_WIDTH         = 24;
  localparam int COUNT_WIDTH_DEF   = 24;
  localparam int MAX_RESULTS       = 3;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = {CAP_WIDTH{1'b1}};

  // Alphabet boundaries
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_PAD     = 8'h3D;

  localparam logic [5:0] SX_LOWER_BASE = 6'h1A;
  localparam logic [5:0] SX_DIGIT_BASE = 6'h34;
  localparam logic [5:0] SX_PLUS       = 6'h3E;
  localparam logic [5:0] SX_SLASH      = 6'h3F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_PAD  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_CAPACITY = 3'd4
  } status_e;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic [1:0]                    cnt;
    result_t [MAX_RESULTS-1:0]     res;
  } group_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t sx;
    sx = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      sx.val = 6'(c - CHR_UPPER_A);
    end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      sx.val = SX_LOWER_BASE + 6'(c - CHR_LOWER_A);
    end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
      sx.val = SX_DIGIT_BASE + 6'(c - CHR_DIGIT_0);
    end else if (c == CHR_PLUS) begin
      sx.val = SX_PLUS;
    end else if (c == CHR_SLASH) begin
      sx.val = SX_SLASH;
    end else if (c == CHR_PAD) begin
      sx.pad = 1'b1;
    end else begin
      sx.bad = 1'b1;
    end
    return sx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/base64_stream_decoder.sv
`default_nettype none

// Streaming base64 (RFC 4648) decoder. One text character enters per valid/ready
// transaction, with end_of_text_i on the final character of a text. Every group
// of four characters yields up to three decoded bytes, one per output
// transaction; a text end with no byte pending gives a single status result with
// byte_valid_o low and last_result_o high. Errors (bad character, data after
// '=', a group with one data character, byte capacity exceeded) give one result
// with last_result_o high and the error code in status_o; bytes already sent
// stay sent, and the rest of that text is dropped silently. The decode is
// single pass: a character is accepted every cycle as long as results drain,
// so throughput is one character per cycle, bounded by the output port at one
// result per cycle (a character that yields three results holds the input
// while those results leave). A character's first result is presented in the
// cycle after its accept. cfg_wdata_i sets the per-text byte capacity
// (reset all ones) and is written when cfg_we_i is high; write it only while
// the decoder is idle. COUNT_WIDTH sets the width of the per-text byte counter.
module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [b64sd_pkg::CAP_WIDTH-1:0] cfg_wdata_i,
  // character input
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      char_byte_i,
  input  wire logic                            end_of_text_i,
  // decoded output
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           data_byte_o,
  output logic                                 byte_valid_o,
  output logic                                 last_result_o,
  output logic [2:0]                           status_o
);
  import b64sd_pkg::*;

  group_t  grp;
  result_t res;
  logic    in_fire;

  // State advances only on an accepted transaction.
  assign in_fire = in_valid_i && in_ready_o;

  b64sd_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .char_i      (char_byte_i),
    .eot_i       (end_of_text_i),
    .grp_o       (grp)
  );

  // Result register: holds the group of one transaction and drains it in order.
  b64sd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .grp_i       (grp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign data_byte_o   = res.data;
  assign byte_valid_o  = res.valid;
  assign last_result_o = res.last;
  assign status_o      = 3'(res.status);

endmodule

`default_nettype wire

// File: rtl/core/b64sd_decode.sv
`default_nettype none

module b64sd_decode #(
  parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [b64sd_pkg::CAP_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                           fire_i,
  input  wire logic [7:0]                     char_i,
  input  wire logic                           eot_i,
  output b64sd_pkg::group_t                   grp_o
);
  import b64sd_pkg::*;

  localparam int CmpW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 2;

  logic [CAP_WIDTH-1:0]   cap_q;
  logic [17:0]            bits_q, bits_d;
  logic [1:0]             fill_q, fill_d;
  logic [2:0]             dchars_q, dchars_d;
  logic                   pad_seen_q, pad_seen_d;
  logic [COUNT_WIDTH-1:0] emitted_q, emitted_d;
  logic                   failed_q, failed_d;

  sextet_t     sx;
  logic        is_data;
  logic [23:0] acc;
  logic [23:0] aligned;
  logic [2:0]  dchars_n;
  logic        closing;
  status_e     pre_status;
  status_e     fin_status;
  logic [1:0]  nbytes;
  logic [1:0]  allowed;
  logic [1:0]  emit;
  logic        err;
  logic [2:0]  room_ok;
  logic [CmpW-1:0] cnt_ext, cap_ext, max_ext;
  logic [7:0]  byte_v [MAX_RESULTS];

  always_comb begin
    sx       = sextet_of(char_i);
    is_data  = !sx.bad && !sx.pad;
    acc      = is_data ? {bits_q, sx.val} : {6'd0, bits_q};
    dchars_n = dchars_q + {2'd0, is_data};
    closing  = (fill_q == 2'd3) || eot_i;

    // Classify the character; bad character wins over bad padding.
    if (sx.bad) begin
      pre_status = ST_BAD_CHAR;
    end else if (is_data && pad_seen_q) begin
      pre_status = ST_BAD_PAD;
    end else if (closing && dchars_n == 3'd1) begin
      pre_status = ST_BAD_LEN;
    end else begin
      pre_status = ST_OK;
    end

    nbytes = (pre_status == ST_OK && closing && dchars_n >= 3'd2) ? 2'(dchars_n - 3'd1) : 2'd0;

    case (dchars_n)
      3'd2:    aligned = acc << 12;
      3'd3:    aligned = acc << 6;
      default: aligned = acc;
    endcase
    byte_v[0] = aligned[23:16];
    byte_v[1] = aligned[15:8];
    byte_v[2] = aligned[7:0];

    // Room check for each of up to three bytes of this transaction.
    cnt_ext = CmpW'(emitted_q);
    cap_ext = CmpW'(cap_q);
    max_ext = CmpW'({COUNT_WIDTH{1'b1}});
    for (int i = 0; i < MAX_RESULTS; i++) begin
      room_ok[i] = ((cnt_ext + CmpW'(i)) < cap_ext) && ((cnt_ext + CmpW'(i)) < max_ext);
    end
    allowed = !room_ok[0] ? 2'd0 : (!room_ok[1] ? 2'd1 : (!room_ok[2] ? 2'd2 : 2'd3));
    emit    = (allowed < nbytes) ? allowed : nbytes;

    if (pre_status == ST_OK && emit < nbytes) begin
      fin_status = ST_CAPACITY;
    end else begin
      fin_status = pre_status;
    end
    err = (fin_status != ST_OK);

    // Assemble the result group.
    grp_o.cnt = failed_q ? 2'd0 :
                (err ? emit + 2'd1 : ((eot_i && emit == 2'd0) ? 2'd1 : emit));
    for (int i = 0; i < MAX_RESULTS; i++) begin
      grp_o.res[i].data   = (2'(i) < emit) ? byte_v[i] : 8'd0;
      grp_o.res[i].valid  = (2'(i) < emit);
      grp_o.res[i].last   = (err && 2'(i) == emit) ||
                            (eot_i && !err && emit != 2'd0 && 2'(i) == emit - 2'd1) ||
                            (eot_i && !err && emit == 2'd0 && i == 0);
      grp_o.res[i].status = (err && 2'(i) == emit) ? fin_status : ST_OK;
    end

    // Text state update.
    bits_d     = bits_q;
    fill_d     = fill_q;
    dchars_d   = dchars_q;
    pad_seen_d = pad_seen_q;
    emitted_d  = emitted_q;
    failed_d   = failed_q;
    if (fire_i) begin
      if (eot_i) begin
        bits_d     = '0;
        fill_d     = '0;
        dchars_d   = '0;
        pad_seen_d = 1'b0;
        emitted_d  = '0;
        failed_d   = 1'b0;
      end else if (failed_q) begin
        failed_d = 1'b1;
      end else if (err) begin
        failed_d = 1'b1;
      end else begin
        if (closing) begin
          bits_d   = '0;
          fill_d   = '0;
          dchars_d = '0;
        end else begin
          bits_d   = acc[17:0];
          fill_d   = fill_q + 2'd1;
          dchars_d = dchars_n;
        end
        pad_seen_d = pad_seen_q | sx.pad;
        emitted_d  = emitted_q + COUNT_WIDTH'(emit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      bits_q     <= '0;
      fill_q     <= '0;
      dchars_q   <= '0;
      pad_seen_q <= 1'b0;
      emitted_q  <= '0;
      failed_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      bits_q     <= bits_d;
      fill_q     <= fill_d;
      dchars_q   <= dchars_d;
      pad_seen_q <= pad_seen_d;
      emitted_q  <= emitted_d;
      failed_q   <= failed_d;
    end
  end

`ifndef ASSERT_OFF
  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && failed_q) |-> (grp_o.cnt == 2'd0))
    else $error("failed text produced results");

  a_empty_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0) |-> (dchars_q == 3'd0 && bits_q == 18'd0))
    else $error("empty group holds data");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && eot_i) |=> (fill_q == 2'd0 && !failed_q && emitted_q == '0))
    else $error("text state not cleared at text end");
`endif

endmodule

`default_nettype wire

// File: rtl/core/b64sd_outq.sv
`default_nettype none

module b64sd_outq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire b64sd_pkg::group_t grp_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output b64sd_pkg::result_t res_o
);
  import b64sd_pkg::*;

  group_t     grp_q;
  logic [1:0] cnt_q;
  logic [1:0] ptr_q;
  logic       load;
  logic       out_fire;
  logic       at_last;

  assign out_valid_o = (cnt_q != 2'd0);
  assign at_last     = (ptr_q == cnt_q - 2'd1);
  assign out_fire    = out_valid_o && out_ready_i;
  // Take a new transaction when the group is empty or its final result leaves now.
  assign in_ready_o  = !out_valid_o || (out_fire && at_last);
  assign load        = in_valid_i && in_ready_o;
  assign res_o       = grp_q.res[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else if (load) begin
      cnt_q <= grp_i.cnt;
      ptr_q <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt_q <= '0;
        ptr_q <= '0;
      end else begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ptr_q < cnt_q))
    else $error("read pointer beyond group");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && grp_i.cnt != 2'd0) |=> out_valid_o)
    else $error("loaded group not presented");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !res_o.valid) |-> res_o.last)
    else $error("non-data result not marked last");
`endif

endmodule

`default_nettype wire
